// File: hw/rtl/fdtdrc_pkg.sv
// Package for the recursive-convolution FDTD cell: sizes, register indexes,
// request codes, lane control struct and the Q16.16 saturation helper.
// No dependencies.
package fdtdrc_pkg;

  localparam int CellsDef = 1024;
  localparam int PolesDef = 3;
  localparam int Axes     = 3;
  localparam int MaxPoles = 3;

  localparam int CellW = 10;
  localparam int ValW  = 32;
  localparam int CfgW  = 64;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CREC0    = 3'd0,
    REG_DCHI0    = 3'd1,
    REG_CREC1    = 3'd2,
    REG_DCHI1    = 3'd3,
    REG_CREC2    = 3'd4,
    REG_DCHI2    = 3'd5,
    REG_D_GAIN   = 3'd6,
    REG_PSI_GAIN = 3'd7
  } cfg_reg_e;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_FIELD  = 1'b1;

  // Control strobes that the top level hands to every accumulator lane.
  typedef struct packed {
    logic rd_en;   // a transaction is accepted, read its row
    logic c_load;  // products move from the multiply stage to the sum stage
    logic wr_en;   // write the row addressed by the write address
    logic clr;     // write zero (reset clearing pass)
  } lane_ctl_t;

  typedef struct packed {
    logic signed [ValW-1:0] val;
    logic                   clip;
  } sat_t;

  function automatic sat_t sat32(input logic signed [47:0] v);
    sat_t r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r.val  = 32'sh7FFF_FFFF;
      r.clip = 1'b1;
    end else if (v < -48'sh0000_8000_0000) begin
      r.val  = -32'sh8000_0000;
      r.clip = 1'b1;
    end else begin
      r.val  = v[ValW-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/fdtdrc_if.sv
// Handshake channel interfaces: request channel and result channel.
// Depends on fdtdrc_pkg for field widths.
interface fdtdrc_req_if import fdtdrc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [CellW-1:0]       cell_req;
  logic signed [ValW-1:0] ex;
  logic signed [ValW-1:0] ey;
  logic signed [ValW-1:0] ez;
  logic [1:0]             axis;
  logic signed [ValW-1:0] e_current;
  logic signed [ValW-1:0] d_component;

  modport source (output valid, req_type, cell_req, ex, ey, ez, axis, e_current,
                  d_component, input ready);
  modport sink (input valid, req_type, cell_req, ex, ey, ez, axis, e_current,
                d_component, output ready);
endinterface

interface fdtdrc_rsp_if import fdtdrc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] e_new;
  logic                   saturated;

  modport source (output valid, e_new, saturated, input ready);
  modport sink (input valid, e_new, saturated, output ready);
endinterface

// File: hw/rtl/fdtdrc_lane.sv
// One accumulator lane (one pole, one axis): row memory, complex
// multiply-add over two stages, rounding and saturation. Uses fdtdrc_pkg.
module fdtdrc_lane import fdtdrc_pkg::*; #(
  parameter int CELLS = CellsDef,
  parameter int AW    = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic                   clk_i,
  input  lane_ctl_t              ctl_i,
  input  logic [AW-1:0]          rd_addr_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  logic [CfgW-1:0]        crec_i,
  input  logic [CfgW-1:0]        dchi_i,
  input  logic signed [ValW-1:0] e_i,
  output logic signed [ValW-1:0] psi_re_o
);

  localparam logic signed [65:0] Half = 66'sd536870912;

  logic [CfgW-1:0] mem [CELLS];
  logic [CfgW-1:0] rd_q;

  logic signed [ValW-1:0] cr, ci, dr, di, pr, pi;
  logic signed [63:0] rr_q, ii_q, dre_q, ri_q, ir_q, die_q;
  logic signed [65:0] sum_r, sum_i;
  sat_t nr, ni;
  logic [CfgW-1:0] wdata;

  assign cr = crec_i[63:32];
  assign ci = crec_i[31:0];
  assign dr = dchi_i[63:32];
  assign di = dchi_i[31:0];
  assign pr = rd_q[63:32];
  assign pi = rd_q[31:0];
  assign psi_re_o = pr;

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_q <= mem[rd_addr_i];
    end
    if (ctl_i.wr_en) begin
      mem[wr_addr_i] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.c_load) begin
      rr_q  <= cr * pr;
      ii_q  <= ci * pi;
      dre_q <= dr * e_i;
      ri_q  <= cr * pi;
      ir_q  <= ci * pr;
      die_q <= di * e_i;
    end
  end

  always_comb begin
    sum_r = 66'(rr_q) - 66'(ii_q) + 66'(dre_q) + Half;
    sum_i = 66'(ri_q) + 66'(ir_q) + 66'(die_q) + Half;
    nr = sat32(48'($signed(sum_r[65:30])));
    ni = sat32(48'($signed(sum_i[65:30])));
    wdata = ctl_i.clr ? '0 : {nr.val, ni.val};
  end

endmodule

// File: hw/rtl/fdtdrc_merge.sv
// Merging stage: picks each pole's real accumulator part on the requested
// axis, scales and sums them with the D term and the current E value, rounds
// and saturates. Uses fdtdrc_pkg.
module fdtdrc_merge import fdtdrc_pkg::*; #(
  parameter int POLES = PolesDef
) (
  input  logic                   clk_i,
  input  logic                   c_load_i,
  input  logic signed [ValW-1:0] psi_re_i [POLES*Axes],
  input  logic [1:0]             axis_i,
  input  logic                   cell_ok_i,
  input  logic signed [ValW-1:0] e_cur_i,
  input  logic signed [ValW-1:0] d_i,
  input  logic signed [ValW-1:0] d_gain_i,
  input  logic signed [ValW-1:0] psi_gain_i,
  output sat_t                   res_o
);

  localparam logic signed [65:0] Half = 66'sd8388608;

  logic signed [63:0]     pd_q;
  logic signed [63:0]     pp_q [POLES];
  logic signed [ValW-1:0] e_q;
  logic signed [ValW-1:0] sel [POLES];
  logic signed [65:0]     sum;
  logic signed [47:0]     tot;

  for (genvar p = 0; p < POLES; p++) begin : g_pole
    always_comb begin
      case (axis_i)
        2'd0:    sel[p] = cell_ok_i ? psi_re_i[p*Axes]     : '0;
        2'd1:    sel[p] = cell_ok_i ? psi_re_i[p*Axes + 1] : '0;
        2'd2:    sel[p] = cell_ok_i ? psi_re_i[p*Axes + 2] : '0;
        default: sel[p] = '0;
      endcase
    end
    always_ff @(posedge clk_i) begin
      if (c_load_i) begin
        pp_q[p] <= psi_gain_i * sel[p];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_load_i) begin
      pd_q <= d_gain_i * d_i;
      e_q  <= e_cur_i;
    end
  end

  always_comb begin
    sum = 66'(pd_q) + Half;
    for (int p = 0; p < POLES; p++) begin
      sum = sum + 66'(pp_q[p]);
    end
    tot = 48'($signed(sum[65:24])) + 48'(e_q);
    res_o = sat32(tot);
  end

endmodule

// File: hw/rtl/fdtd_recursive_convolution_cell.sv
// Top level of the recursive-convolution FDTD dispersive cell: config
// registers, pipeline control, accumulator lanes and merging stage.
// Uses fdtdrc_pkg, fdtdrc_if, fdtdrc_lane and fdtdrc_merge.
//
//  channel  | dir | payload                                          | handshake
//  req_i    | in  | req_type cell_req ex ey ez axis e_current d_comp | valid/ready
//  rsp_o    | out | e_new saturated                                  | valid/ready
//  cfg_*    | in  | cfg_idx_i cfg_wdata_i                            | cfg_we_i
//
// One transaction enters per cycle unless back-pressure, a cell hazard or the
// clearing pass holds ready low. Every pole/axis accumulator lane reads its
// row at acceptance, multiplies in stage B and sums, rounds and writes back
// in stage C. A request whose cell matches an update still in the multiply
// or sum stage waits until that write-back is done. After reset the block
// clears all CELLS accumulator rows, one row per cycle, before taking
// requests. A stalled result stalls the sum stage only for field requests.
module fdtd_recursive_convolution_cell import fdtdrc_pkg::*; #(
  parameter int CELLS = CellsDef,
  parameter int POLES = PolesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  fdtdrc_req_if.sink           req_i,
  fdtdrc_rsp_if.source         rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_wdata_i
);

  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int LANES = POLES * Axes;

  // Configuration registers.
  logic [CfgW-1:0]        crec_q [MaxPoles];
  logic [CfgW-1:0]        dchi_q [MaxPoles];
  logic signed [ValW-1:0] d_gain_q, psi_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < MaxPoles; p++) begin
        crec_q[p] <= '0;
        dchi_q[p] <= '0;
      end
      d_gain_q   <= '0;
      psi_gain_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CREC0:    crec_q[0]  <= cfg_wdata_i;
        REG_DCHI0:    dchi_q[0]  <= cfg_wdata_i;
        REG_CREC1:    crec_q[1]  <= cfg_wdata_i;
        REG_DCHI1:    dchi_q[1]  <= cfg_wdata_i;
        REG_CREC2:    crec_q[2]  <= cfg_wdata_i;
        REG_DCHI2:    dchi_q[2]  <= cfg_wdata_i;
        REG_D_GAIN:   d_gain_q   <= cfg_wdata_i[ValW-1:0];
        REG_PSI_GAIN: psi_gain_q <= cfg_wdata_i[ValW-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass after reset: one row of every lane per cycle.
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(CELLS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Pipeline state: B is the multiply stage, C the sum stage.
  logic                   b_v_q, c_v_q, out_v_q;
  logic                   b_type_q, c_type_q;
  logic                   b_ok_q, c_ok_q;
  logic [CellW-1:0]       b_cell_q, c_cell_q;
  logic [1:0]             b_axis_q;
  logic signed [ValW-1:0] b_e_q [Axes];
  logic signed [ValW-1:0] b_ecur_q, b_d_q;
  logic signed [ValW-1:0] out_e_q;
  logic                   out_sat_q;

  logic out_free, c_free, b_free, c_load, hazard, accept, c_upd;
  sat_t res;

  assign c_upd    = (c_type_q == REQ_UPDATE);
  assign out_free = !out_v_q || rsp_o.ready;
  assign c_free   = !c_v_q || c_upd || out_free;
  assign b_free   = !b_v_q || c_free;
  assign c_load   = b_v_q && c_free;

  // An update still ahead in the pipeline on the same cell has not been
  // written back yet; hold the request until it is.
  assign hazard = (b_v_q && (b_type_q == REQ_UPDATE) && (b_cell_q == req_i.cell_req)) ||
                  (c_v_q && c_upd && (c_cell_q == req_i.cell_req));

  assign req_i.ready = b_free && !hazard && !clr_q;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (b_free) begin
        b_v_q <= accept;
      end
      if (c_free) begin
        c_v_q <= b_v_q;
      end
      if (out_free) begin
        out_v_q <= c_v_q && !c_upd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_type_q <= req_i.req_type;
      b_ok_q   <= (32'(req_i.cell_req) < CELLS);
      b_cell_q <= req_i.cell_req;
      b_axis_q <= req_i.axis;
      b_e_q[0] <= req_i.ex;
      b_e_q[1] <= req_i.ey;
      b_e_q[2] <= req_i.ez;
      b_ecur_q <= req_i.e_current;
      b_d_q    <= req_i.d_component;
    end
    if (c_load) begin
      c_type_q <= b_type_q;
      c_ok_q   <= b_ok_q;
      c_cell_q <= b_cell_q;
    end
    if (out_free) begin
      out_e_q   <= res.val;
      out_sat_q <= res.clip;
    end
  end

  // Lane control.
  lane_ctl_t     ctl;
  logic [AW-1:0] wr_addr;

  assign ctl.rd_en  = accept;
  assign ctl.c_load = c_load;
  assign ctl.clr    = clr_q;
  assign ctl.wr_en  = clr_q || (c_v_q && c_upd && c_ok_q);
  assign wr_addr    = clr_q ? clr_cnt_q : AW'(c_cell_q);

  logic signed [ValW-1:0] psi_re [LANES];

  for (genvar p = 0; p < POLES; p++) begin : g_pole
    for (genvar a = 0; a < Axes; a++) begin : g_axis
      fdtdrc_lane #(
        .CELLS (CELLS),
        .AW    (AW)
      ) u_lane (
        .clk_i     (clk_i),
        .ctl_i     (ctl),
        .rd_addr_i (AW'(req_i.cell_req)),
        .wr_addr_i (wr_addr),
        .crec_i    (crec_q[p]),
        .dchi_i    (dchi_q[p]),
        .e_i       (b_e_q[a]),
        .psi_re_o  (psi_re[p*Axes + a])
      );
    end
  end

  fdtdrc_merge #(
    .POLES (POLES)
  ) u_merge (
    .clk_i      (clk_i),
    .c_load_i   (c_load),
    .psi_re_i   (psi_re),
    .axis_i     (b_axis_q),
    .cell_ok_i  (b_ok_q),
    .e_cur_i    (b_ecur_q),
    .d_i        (b_d_q),
    .d_gain_i   (d_gain_q),
    .psi_gain_i (psi_gain_q),
    .res_o      (res)
  );

  assign rsp_o.valid     = out_v_q;
  assign rsp_o.e_new     = out_e_q;
  assign rsp_o.saturated = out_sat_q;

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the recursive-convolution FDTD dispersive cell.
// Depends on fdtdrc_pkg, the fdtdrc_req_if/fdtdrc_rsp_if interfaces and the
// fdtd_recursive_convolution_cell top level.
module tb_top;
  import fdtdrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCells   = CellsDef;
  localparam int NPoles   = PolesDef;
  localparam int CycLimit = 400000;
  localparam int HoldLen  = 300;

  // One request transaction as the sender offers it.
  typedef struct {
    logic                   req_type;
    logic [CellW-1:0]       cell_idx;
    logic signed [ValW-1:0] ex;
    logic signed [ValW-1:0] ey;
    logic signed [ValW-1:0] ez;
    logic [1:0]             axis;
    logic signed [ValW-1:0] e_cur;
    logic signed [ValW-1:0] d_comp;
  } field_req_t;

  // One result transaction as the block should return it.
  typedef struct {
    logic signed [ValW-1:0] e_new;
    logic                   sat;
  } e_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0]   cfg_wdata = '0;

  fdtdrc_req_if req_if ();
  fdtdrc_rsp_if rsp_if ();

  fdtd_recursive_convolution_cell i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Bench copy of the register file and of the accumulator memory.
  logic [CfgW-1:0] model_regs [8];
  logic [63:0]     model_psi [NCells][NPoles][Axes];

  field_req_t pending_reqs [$];
  e_result_t  expected_e [$];

  int errors    = 0;
  int n_updates = 0;
  int n_fields  = 0;
  int n_checked = 0;
  int cycles    = 0;
  logic hold_trig = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, n_checked);
    errors++;
  endtask

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] clip32(input logic signed [79:0] v,
                                                output logic clipped);
    clipped = 1'b0;
    if (v > 80'sd2147483647) begin
      clipped = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -80'sd2147483648) begin
      clipped = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Complex multiply-add of every pole/axis accumulator of one cell.
  task automatic apply_psi_update(input field_req_t r);
    logic signed [79:0] cr, ci, dr, di, pr, pi, e, sr, si;
    logic signed [31:0] nr, ni;
    logic clipped;
    if (int'(r.cell_idx) >= NCells) return;
    for (int p = 0; p < NPoles; p++) begin
      cr = $signed(model_regs[2*p][63:32]);
      ci = $signed(model_regs[2*p][31:0]);
      dr = $signed(model_regs[2*p+1][63:32]);
      di = $signed(model_regs[2*p+1][31:0]);
      for (int a = 0; a < Axes; a++) begin
        pr = $signed(model_psi[r.cell_idx][p][a][63:32]);
        pi = $signed(model_psi[r.cell_idx][p][a][31:0]);
        e  = (a == 0) ? r.ex : (a == 1) ? r.ey : r.ez;
        // Round half up at the Q2.30 boundary, then clip each part.
        sr = (cr * pr - ci * pi + dr * e + 80'sh2000_0000) >>> 30;
        si = (cr * pi + ci * pr + di * e + 80'sh2000_0000) >>> 30;
        nr = clip32(sr, clipped);
        ni = clip32(si, clipped);
        model_psi[r.cell_idx][p][a] = {nr, ni};
      end
    end
  endtask

  function automatic e_result_t predict_e_new(input field_req_t r);
    logic signed [79:0] acc, g, dg, d;
    e_result_t res;
    dg  = $signed(model_regs[REG_D_GAIN][31:0]);
    g   = $signed(model_regs[REG_PSI_GAIN][31:0]);
    d   = r.d_comp;
    acc = dg * d;
    if (int'(r.cell_idx) < NCells && r.axis < Axes) begin
      for (int p = 0; p < NPoles; p++)
        acc += g * $signed(model_psi[r.cell_idx][p][r.axis][63:32]);
    end
    acc = ((acc + 80'sh80_0000) >>> 24) + r.e_cur;
    res.e_new = clip32(acc, res.sat);
    return res;
  endfunction

  // Driver: bursts of random length separated by random gaps. The expected
  // result is worked out when the transaction is accepted.
  int burst_left = 0;
  int gap_left   = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (!req_if.valid || req_if.ready) begin
      if (req_if.valid && req_if.ready) begin
        if (pending_reqs[0].req_type == REQ_UPDATE) begin
          apply_psi_update(pending_reqs[0]);
          n_updates++;
        end else begin
          expected_e.push_back(predict_e_new(pending_reqs[0]));
          n_fields++;
        end
        void'(pending_reqs.pop_front());
      end
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        req_if.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        req_if.valid       <= 1'b1;
        req_if.req_type    <= pending_reqs[0].req_type;
        req_if.cell_req    <= pending_reqs[0].cell_idx;
        req_if.ex          <= pending_reqs[0].ex;
        req_if.ey          <= pending_reqs[0].ey;
        req_if.ez          <= pending_reqs[0].ez;
        req_if.axis        <= pending_reqs[0].axis;
        req_if.e_current   <= pending_reqs[0].e_cur;
        req_if.d_component <= pending_reqs[0].d_comp;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver: a stall pattern with a randomly redrawn period and duty, plus one
  // long hold-off on request from the stimulus.
  int hold_left = 0;
  int st_period = 5;
  int st_duty   = 1;
  int st_phase  = 0;
  always @(posedge clk_i) begin
    if (cycles % 64 == 0) begin
      st_period = $urandom_range(2, 9);
      st_duty   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, st_period - 1);
    end
    st_phase = (st_phase + 1) % st_period;
    if (hold_trig) begin
      hold_trig <= 1'b0;
      hold_left = HoldLen;
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= (st_phase >= st_duty);
    end
  end

  // Monitor: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready) begin
      if (expected_e.size() == 0) begin
        report_mismatch("unexpected result", rsp_if.e_new, 32'h0);
      end else begin
        if (rsp_if.e_new !== expected_e[0].e_new)
          report_mismatch("e_new", rsp_if.e_new, expected_e[0].e_new);
        if (rsp_if.saturated !== expected_e[0].sat)
          report_mismatch("saturated", 32'(rsp_if.saturated), 32'(expected_e[0].sat));
        void'(expected_e.pop_front());
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CycLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    model_regs[idx] = (idx >= REG_D_GAIN) ? {32'h0, val[31:0]} : val;
  endtask

  task automatic load_regs(input logic [CfgW-1:0] v [8]);
    for (int i = 0; i < 8; i++) write_reg(cfg_reg_e'(i), v[i]);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 4))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic field_req_t mk_req(input logic t, input int cell_idx, input int ax,
                                        input logic signed [31:0] x, y, z, ec, dc);
    field_req_t r;
    r.req_type = t;
    r.cell_idx = CellW'(cell_idx);
    r.axis     = 2'(ax);
    r.ex       = x;
    r.ey       = y;
    r.ez       = z;
    r.e_cur    = ec;
    r.d_comp   = dc;
    return r;
  endfunction

  // Mostly updates and reads on a small pool of cells so that accumulators
  // build up; the rest is noise over the whole field range.
  task automatic queue_random(input int n);
    field_req_t r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        r = mk_req(1'($urandom_range(0, 1)), $urandom_range(0, 7), $urandom_range(0, 2),
                   rand_val(), rand_val(), rand_val(), rand_val(), rand_val());
      end else begin
        r = mk_req(1'($urandom_range(0, 1)), $urandom_range(0, 1023), $urandom_range(0, 3),
                   $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end
      pending_reqs.push_back(r);
    end
  endtask

  // Sender pause: nothing more is offered until every result has come and
  // any trailing update has been written back.
  task automatic drain();
    wait (pending_reqs.size() == 0 && expected_e.size() == 0 && !req_if.valid);
    repeat (10) @(posedge clk_i);
  endtask

  logic [CfgW-1:0] cfg_set [8];

  initial begin
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_UPDATE;
    req_if.cell_req    = '0;
    req_if.ex          = '0;
    req_if.ey          = '0;
    req_if.ez          = '0;
    req_if.axis        = '0;
    req_if.e_current   = '0;
    req_if.d_component = '0;
    rsp_if.ready       = 1'b0;
    for (int i = 0; i < 8; i++) model_regs[i] = '0;
    for (int c = 0; c < NCells; c++)
      for (int p = 0; p < NPoles; p++)
        for (int a = 0; a < Axes; a++) model_psi[c][p][a] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Setting 1: decaying poles with unity gains, used by the directed part.
    cfg_set = '{64'h3999_9999_0400_0000, 64'h2000_0000_F000_0000,
                64'h3000_0000_FC00_0000, 64'h1000_0000_0800_0000,
                64'h2000_0000_0000_0000, 64'hE000_0000_0000_0000,
                64'h0100_0000,           64'h0100_0000};
    load_regs(cfg_set);
    // Field read of the cleared store, then updates with extreme E values.
    pending_reqs.push_back(mk_req(REQ_FIELD, 0, 0, 0, 0, 0, 32'sh1234, 32'sh10000));
    pending_reqs.push_back(mk_req(REQ_UPDATE, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                  0, 0, 0));
    pending_reqs.push_back(mk_req(REQ_FIELD, 0, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(REQ_FIELD, 0, 1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(REQ_FIELD, 0, 2, 0, 0, 0, 0, 0));
    // Axis three reads no accumulator.
    pending_reqs.push_back(mk_req(REQ_FIELD, 0, 3, 0, 0, 0, 32'sh100, 32'sh200));
    // An update ignores axis and field-request payload, and vice versa.
    pending_reqs.push_back(mk_req(REQ_UPDATE, 1023, 3, -1, 32'sh10000, 32'sh7FFF_FFFF,
                                  32'sh5555_5555, 32'shAAAA_AAAA));
    pending_reqs.push_back(mk_req(REQ_FIELD, 1023, 0, 32'shDEAD_BEEF, -1, -1, 0, 0));
    pending_reqs.push_back(mk_req(REQ_FIELD, 1023, 2, 0, 0, 0, 0, 0));
    // Back-to-back updates of one cell, then reads of it.
    pending_reqs.push_back(mk_req(REQ_UPDATE, 5, 0, 32'sh1_0000, 32'sh2_0000,
                                  -32'sh3_0000, 0, 0));
    pending_reqs.push_back(mk_req(REQ_UPDATE, 5, 0, 32'sh1_0000, 32'sh2_0000,
                                  -32'sh3_0000, 0, 0));
    pending_reqs.push_back(mk_req(REQ_FIELD, 5, 1, 0, 0, 0, 32'sh8000, 0));
    pending_reqs.push_back(mk_req(REQ_UPDATE, 5, 0, 32'sh8000_0000, 0, 0, 0, 0));
    pending_reqs.push_back(mk_req(REQ_FIELD, 5, 0, 0, 0, 0, 0, 0));
    // Field value clipped upward and downward.
    pending_reqs.push_back(mk_req(REQ_FIELD, 6, 0, 0, 0, 0, 32'sh7FFF_FFFF,
                                  32'sh7FFF_FFFF));
    pending_reqs.push_back(mk_req(REQ_FIELD, 6, 1, 0, 0, 0, 32'sh8000_0000,
                                  32'sh8000_0000));
    pending_reqs.push_back(mk_req(REQ_FIELD, 6, 2, 0, 0, 0, 32'sh7FFF_FFFF, 0));
    queue_random(100);
    drain();

    // Setting 2: fully random registers; the receiver holds off for a long
    // stretch while the sender keeps offering transactions.
    for (int i = 0; i < 8; i++) cfg_set[i] = {$urandom(), $urandom()};
    load_regs(cfg_set);
    queue_random(130);
    @(posedge clk_i);
    hold_trig <= 1'b1;
    drain();

    // Setting 3: extreme coefficients and gains, accumulators saturate.
    cfg_set = '{64'h7FFF_FFFF_8000_0000, 64'h7FFF_FFFF_7FFF_FFFF,
                64'h8000_0000_7FFF_FFFF, 64'h8000_0000_8000_0000,
                64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_8000_0000,
                64'h7FFF_FFFF,           64'h8000_0000};
    load_regs(cfg_set);
    queue_random(120);
    drain();

    // Setting 4: everything zero, so only e_current passes through.
    for (int i = 0; i < 8; i++) cfg_set[i] = '0;
    load_regs(cfg_set);
    queue_random(60);
    drain();

    // Setting 5: random coefficients up to one in magnitude, a random D gain and a moderate psi gain.
    for (int i = 0; i < 6; i++)
      cfg_set[i] = {$signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000,
                    $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000};
    cfg_set[6] = {32'h0, $urandom()};
    cfg_set[7] = {32'h0, 32'($signed($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000)};
    load_regs(cfg_set);
    queue_random(190);
    drain();

    if (expected_e.size() != 0) begin
      report_mismatch("results never arrived", 32'(expected_e.size()), 32'h0);
    end
    $display("covered %0d updates and %0d field requests over five register settings",
             n_updates, n_fields);
    $display("%0d results compared, %0d mismatches, %0d cycles", n_checked, errors, cycles);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/fdtdrc_pkg.sv
hw/rtl/fdtdrc_if.sv
hw/rtl/fdtdrc_lane.sv
hw/rtl/fdtdrc_merge.sv
hw/rtl/fdtd_recursive_convolution_cell.sv
bench/tb_top.sv
